FILE: hw/rtl/flhc_pkg.sv
package flhc_pkg;

    typedef logic signed [8:0]  temp_t;
    typedef logic signed [15:0] wide_temp_t;
    typedef logic [13:0]        bias_t;
    typedef logic [3:0]         sleep_t;
    typedef logic [4:0]         gain_t;
    typedef logic [6:0]         keep_t;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] REG_SLEEP  = 2'd0;
    localparam logic [1:0] REG_BIAS   = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    localparam sleep_t     SLEEP_RST  = 4'd5;
    localparam gain_t      GAIN_RST   = 5'd5;
    localparam logic [3:0] LEVELS_RST = 4'd8;
    localparam keep_t      KEEP_RST   = 7'd30;
    localparam keep_t      KEEP_MULT  = 7'd6;
    localparam sleep_t     SLEEP_RISE = 4'd2;

    localparam bias_t       BIAS_MAX  = 14'h3FFF;
    // ceil(2^22 / 10): exact x/10 for x below 2^19
    localparam logic [18:0] RECIP_10  = 19'd419431;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 24;

    // ceil(4*(g+1)/10), the bias decay per sample
    function automatic logic [3:0] decay_step(input gain_t g);
        logic [7:0]  x;
        logic [15:0] m;
        x = 8'({3'b000, g} * 8'd4) + 8'd13;
        m = 16'(x) * 16'd205;
        return m[14:11];
    endfunction

    function automatic wide_temp_t ext_temp(input logic [8:0] t);
        return wide_temp_t'({{7{t[8]}}, t});
    endfunction

endpackage

FILE: hw/rtl/flhc_ram.sv
module flhc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fan_level_hysteresis_controller_core.sv
// Input transfer to m_tvalid: load, restart or unused opcode go straight to ST_OUT;
// a first sample adds a read and compare per level stepped down from the top entry;
// a later sample runs ST_PREP, on a rise three passes through the one 19x19 multiplier
// and saturation, ST_BSUM, a read and compare per level stepped by the table walk, and
// ST_DECAY. s_tready returns with m_tvalid; a result still held stalls the next in ST_OUT.
// aresetn (synchronous) restores the register defaults; the level table is not cleared.
module fan_level_hysteresis_controller_core
    import flhc_pkg::*;
#(
    parameter int MAX_LEVELS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [4:0]             cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index, entry_low, entry_high, temperature, zero pad
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // fan_level, level_write, keepalive_write, next_sleep, bias_value, zero pad
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_LEVELS);
    localparam logic [7:0] MAX_L8 = 8'(MAX_LEVELS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT_RD  = 4'd1;
    localparam logic [3:0] ST_INIT_CMP = 4'd2;
    localparam logic [3:0] ST_PREP     = 4'd3;
    localparam logic [3:0] ST_MUL1     = 4'd4;
    localparam logic [3:0] ST_MUL2     = 4'd5;
    localparam logic [3:0] ST_MUL3     = 4'd6;
    localparam logic [3:0] ST_SAT      = 4'd7;
    localparam logic [3:0] ST_BSUM     = 4'd8;
    localparam logic [3:0] ST_UP_RD    = 4'd9;
    localparam logic [3:0] ST_UP_CMP   = 4'd10;
    localparam logic [3:0] ST_DN_RD    = 4'd11;
    localparam logic [3:0] ST_DN_CMP   = 4'd12;
    localparam logic [3:0] ST_DECAY    = 4'd13;
    localparam logic [3:0] ST_OUT      = 4'd14;

    logic [3:0]             state_reg, state_next;
    sleep_t                 cfg_sleep_reg, cfg_sleep_next;
    gain_t                  cfg_gain_reg, cfg_gain_next;
    logic [3:0]             cfg_levels_reg, cfg_levels_next;
    logic [AW-1:0]          level_reg, level_next;
    temp_t                  prev_temp_reg, prev_temp_next;
    bias_t                  bias_reg, bias_next;
    sleep_t                 sleep_reg, sleep_next;
    keep_t                  keep_reg, keep_next;
    logic                   started_reg, started_next;
    temp_t                  temp_reg, temp_next;
    logic [AW-1:0]          lvl_reg, lvl_next;
    sleep_t                 st_reg, st_next;
    bias_t                  wbias_reg, wbias_next;
    logic [8:0]             dm1_reg, dm1_next;
    wide_temp_t             bsum_reg, bsum_next;
    logic [37:0]            prod_reg, prod_next;
    logic                   lw_reg, lw_next;
    logic                   kw_reg, kw_next;
    logic                   m_valid_reg, m_valid_next;
    logic [TDATA_OUT_W-1:0] m_data_reg, m_data_next;

    logic                   accept;
    logic [1:0]             in_op;
    logic [2:0]             in_idx;
    logic                   ram_we;
    logic [17:0]            ram_rdata;
    logic [7:0]             top8;
    logic [AW-1:0]          top_lvl;
    logic [18:0]            mul_a, mul_b;
    logic [37:0]            mul_p;
    logic signed [7:0]      ka;
    logic signed [9:0]      diff;
    wide_temp_t             lim_hi, lim_lo;
    temp_t                  lim_lo9;
    keep_t                  keep_reload;
    logic [3:0]             dstep;

    assign accept = s_tvalid && s_tready;
    assign in_op  = s_tuser;
    assign in_idx = s_tdata[2:0];
    assign ram_we = accept && (in_op == OP_LOAD) && ({5'b00000, in_idx} < MAX_L8);

    flhc_ram #(
        .WIDTH(18),
        .DEPTH(MAX_LEVELS)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(AW'(in_idx)),
        .wr_data({s_tdata[20:12], s_tdata[11:3]}),
        .rd_addr(lvl_reg),
        .rd_data(ram_rdata)
    );

    always_comb begin
        if (cfg_levels_reg == 4'd0) begin
            top8 = 8'd0;
        end else if ({4'b0000, cfg_levels_reg} >= MAX_L8) begin
            top8 = MAX_L8 - 8'd1;
        end else begin
            top8 = {4'b0000, cfg_levels_reg} - 8'd1;
        end
    end
    assign top_lvl = AW'(top8);

    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                mul_a = 19'(sleep_reg);
                mul_b = 19'(cfg_gain_reg);
            end
            ST_MUL2: begin
                mul_a = prod_reg[18:0];
                mul_b = 19'(dm1_reg);
            end
            default: begin
                mul_a = prod_reg[18:0];
                mul_b = RECIP_10;
            end
        endcase
    end
    assign mul_p = {19'b0, mul_a} * {19'b0, mul_b};

    assign ka          = $signed({1'b0, keep_reg}) - $signed({4'b0000, sleep_reg});
    assign diff        = $signed({temp_reg[8], temp_reg})
                       - $signed({prev_temp_reg[8], prev_temp_reg});
    assign lim_hi      = ext_temp(ram_rdata[17:9]);
    assign lim_lo      = ext_temp(ram_rdata[8:0]);
    assign lim_lo9     = temp_t'(ram_rdata[8:0]);
    assign keep_reload = 7'(cfg_sleep_reg) * KEEP_MULT;
    assign dstep       = decay_step(cfg_gain_reg);

    always_comb begin
        state_next      = state_reg;
        cfg_sleep_next  = cfg_sleep_reg;
        cfg_gain_next   = cfg_gain_reg;
        cfg_levels_next = cfg_levels_reg;
        level_next      = level_reg;
        prev_temp_next  = prev_temp_reg;
        bias_next       = bias_reg;
        sleep_next      = sleep_reg;
        keep_next       = keep_reg;
        started_next    = started_reg;
        temp_next       = temp_reg;
        lvl_next        = lvl_reg;
        st_next         = st_reg;
        wbias_next      = wbias_reg;
        dm1_next        = dm1_reg;
        bsum_next       = bsum_reg;
        prod_next       = prod_reg;
        lw_next         = lw_reg;
        kw_next         = kw_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SLEEP:  cfg_sleep_next  = cfg_wdata[3:0];
                REG_BIAS:   cfg_gain_next   = cfg_wdata;
                REG_LEVELS: cfg_levels_next = cfg_wdata[3:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    lw_next    = 1'b0;
                    kw_next    = 1'b0;
                    temp_next  = temp_t'(s_tdata[29:21]);
                    state_next = ST_OUT;
                    if (in_op == OP_RESTART) begin
                        started_next = 1'b0;
                    end else if (in_op == OP_SAMPLE) begin
                        lvl_next   = top_lvl;
                        state_next = started_reg ? ST_PREP : ST_INIT_RD;
                    end
                end
            end
            ST_INIT_RD: begin
                state_next = ST_INIT_CMP;
            end
            ST_INIT_CMP: begin
                if ((temp_reg <= lim_lo9) && (lvl_reg != '0)) begin
                    lvl_next   = AW'(lvl_reg - 1'b1);
                    state_next = ST_INIT_RD;
                end else begin
                    level_next     = lvl_reg;
                    lw_next        = 1'b1;
                    keep_next      = keep_reload;
                    sleep_next     = cfg_sleep_reg;
                    bias_next      = '0;
                    prev_temp_next = temp_reg;
                    started_next   = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_PREP: begin
                lvl_next = (level_reg > top_lvl) ? top_lvl : level_reg;
                if (ka <= $signed({4'b0000, cfg_sleep_reg})) begin
                    kw_next   = 1'b1;
                    keep_next = keep_reload;
                end else begin
                    keep_next = ka[6:0];
                end
                if (diff >= 10'sd2) begin
                    dm1_next   = 9'(diff - 10'sd1);
                    st_next    = (sleep_reg > SLEEP_RISE) ? SLEEP_RISE : sleep_reg;
                    state_next = ST_MUL1;
                end else begin
                    st_next    = (sleep_reg < cfg_sleep_reg) ? sleep_t'(sleep_reg + 1'b1)
                                                             : sleep_reg;
                    wbias_next = bias_reg;
                    state_next = ST_BSUM;
                end
            end
            ST_MUL1: begin
                prod_next  = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                prod_next  = mul_p;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                prod_next  = mul_p;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                wbias_next = (prod_reg[37:36] != 2'b00) ? BIAS_MAX : prod_reg[35:22];
                state_next = ST_BSUM;
            end
            ST_BSUM: begin
                bsum_next  = ext_temp(temp_reg) + wide_temp_t'({2'b00, wbias_reg});
                state_next = ST_UP_RD;
            end
            ST_UP_RD: begin
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (bsum_reg >= lim_hi) begin
                    lw_next = 1'b1;
                end
                if ((bsum_reg >= lim_hi) && (lvl_reg < top_lvl)) begin
                    lvl_next   = AW'(lvl_reg + 1'b1);
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_RD: begin
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (bsum_reg <= lim_lo) begin
                    lw_next = 1'b1;
                    st_next = cfg_sleep_reg;
                end
                if ((bsum_reg <= lim_lo) && (lvl_reg != '0)) begin
                    lvl_next   = AW'(lvl_reg - 1'b1);
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DECAY;
                end
            end
            ST_DECAY: begin
                if (wbias_reg > 14'(dstep)) begin
                    bias_next = wbias_reg - 14'(dstep);
                end else begin
                    bias_next = '0;
                end
                level_next     = lvl_reg;
                sleep_next     = st_reg;
                prev_temp_next = temp_reg;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, bias_reg, sleep_reg, kw_reg, lw_reg, 3'(level_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_sleep_reg  <= SLEEP_RST;
            cfg_gain_reg   <= GAIN_RST;
            cfg_levels_reg <= LEVELS_RST;
            level_reg      <= '0;
            prev_temp_reg  <= '0;
            bias_reg       <= '0;
            sleep_reg      <= SLEEP_RST;
            keep_reg       <= KEEP_RST;
            started_reg    <= 1'b0;
            lw_reg         <= 1'b0;
            kw_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_sleep_reg  <= cfg_sleep_next;
            cfg_gain_reg   <= cfg_gain_next;
            cfg_levels_reg <= cfg_levels_next;
            level_reg      <= level_next;
            prev_temp_reg  <= prev_temp_next;
            bias_reg       <= bias_next;
            sleep_reg      <= sleep_next;
            keep_reg       <= keep_next;
            started_reg    <= started_next;
            lw_reg         <= lw_next;
            kw_reg         <= kw_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_reg   <= temp_next;
        lvl_reg    <= lvl_next;
        st_reg     <= st_next;
        wbias_reg  <= wbias_next;
        dm1_reg    <= dm1_next;
        bsum_reg   <= bsum_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
